// ===== hw/rtl/ts_section_assembler_crc_unit_macros.svh =====
// ----------------------------------------------------------------------------
// TS section assembler - assertion macros
// Shorthand for the concurrent checks of the section assembler, sampled on
// clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TS_SECTION_ASSEMBLER_CRC_UNIT_MACROS_SVH
`define TS_SECTION_ASSEMBLER_CRC_UNIT_MACROS_SVH

// Same-cycle implication.
`define TSSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ts_sa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TS section assembler package
// Shared constants and the structs passed between framer, section unit and top.
// ----------------------------------------------------------------------------
package ts_sa_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'h47;
  localparam logic [7:0]  STUFF_BYTE     = 8'hFF;
  localparam logic [31:0] CRC_POLY       = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [12:0] SEC_TOTAL_INIT = 13'd4;

  // register index (paddr[2])
  localparam logic REG_PID_FILTER = 1'b0;

  // framer -> section unit, one item's worth of decode
  typedef struct packed {
    logic pkt_start;  // first header byte after sync
    logic sec_reset;  // pointer byte of a matching start packet
    logic payload;    // payload byte of a matching packet
  } ts_sa_ctl_t;

  typedef struct packed {
    logic hunting;
    logic pos_zero;
  } ts_sa_frm_stat_t;

  typedef struct packed {
    logic in_section;
    logic stuffing;
    logic cnt_below_total;
  } ts_sa_sec_stat_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [47:0] mac_address;
    logic [12:0] es_pid;
    logic [7:0]  stream_type;
    logic [12:0] map_pid;
    logic [15:0] first_program;
    logic [4:0]  version;
    logic [15:0] table_id_extension;
    logic [12:0] section_bytes;
    logic        crc_ok;
  } ts_sa_result_t;

endpackage

// ===== hw/rtl/ts_sa_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TS section assembler - packet framer
// Sync hunt, packet position count and header decode (start flag, PID match).
// ----------------------------------------------------------------------------
module ts_sa_framer
  import ts_sa_pkg::*;
#(
  parameter int PACKET_BYTES = 188
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      byte_i,
  input  logic [12:0]     pid_filter,
  output ts_sa_ctl_t      ctl,
  output ts_sa_frm_stat_t stat
);

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  logic             hunting_r, hunting_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [4:0]       pid_high_r, pid_high_nxt;
  logic             start_flag_r, start_flag_nxt;
  logic             pid_match_r, pid_match_nxt;

  always_comb begin
    hunting_nxt    = hunting_r;
    pos_nxt        = pos_r;
    pid_high_nxt   = pid_high_r;
    start_flag_nxt = start_flag_r;
    pid_match_nxt  = pid_match_r;
    ctl            = '0;
    if (step) begin
      if (hunting_r) begin
        if (byte_i == SYNC_BYTE) begin
          hunting_nxt = 1'b0;
          pos_nxt     = POS_W'(1);
        end
      end else begin
        if (pos_r == POS_W'(1)) begin
          pid_high_nxt   = byte_i[4:0];
          start_flag_nxt = byte_i[6];
          ctl.pkt_start  = 1'b1;
        end else if (pos_r == POS_W'(2)) begin
          pid_match_nxt = ({pid_high_r, byte_i} == pid_filter);
        end else if (pos_r == POS_W'(4) && start_flag_r) begin
          ctl.sec_reset = pid_match_r;  // pointer field, assumed zero
        end else if (pos_r >= POS_W'(4) && pid_match_r) begin
          ctl.payload = 1'b1;
        end
        if (pos_r == LAST_POS) begin
          hunting_nxt = 1'b1;
          pos_nxt     = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r    <= 1'b1;
      pos_r        <= '0;
      pid_high_r   <= '0;
      start_flag_r <= 1'b0;
      pid_match_r  <= 1'b0;
    end else begin
      hunting_r    <= hunting_nxt;
      pos_r        <= pos_nxt;
      pid_high_r   <= pid_high_nxt;
      start_flag_r <= start_flag_nxt;
      pid_match_r  <= pid_match_nxt;
    end
  end

  assign stat.hunting  = hunting_r;
  assign stat.pos_zero = (pos_r == '0);

endmodule

// ===== hw/rtl/ts_sa_section.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TS section assembler - section unit
// Section open/close, length tracking, byte-wide CRC-32 and header capture.
// ----------------------------------------------------------------------------
module ts_sa_section
  import ts_sa_pkg::*;
#(
  parameter int CAPTURE_BYTES = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ts_sa_ctl_t      ctl,
  input  logic [7:0]      byte_i,
  output logic            res_valid,
  output ts_sa_result_t   res,
  output ts_sa_sec_stat_t stat
);

  localparam int IDX_W = $clog2(CAPTURE_BYTES);

  // MSB-first CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = b[i] ^ c[31];
      c  = {c[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  logic        in_section_r, in_section_nxt;
  logic        stuffing_r, stuffing_nxt;
  logic [12:0] count_r, count_nxt;
  logic [12:0] total_r, total_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  cap_r   [CAPTURE_BYTES];
  logic [7:0]  cap_nxt [CAPTURE_BYTES];

  logic        open_sec;
  logic        take;
  logic [12:0] count_b;
  logic [12:0] total_b;
  logic [31:0] crc_b;

  always_comb begin
    in_section_nxt = in_section_r;
    stuffing_nxt   = stuffing_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    crc_nxt        = crc_r;
    cap_nxt        = cap_r;
    res_valid      = 1'b0;
    open_sec       = 1'b0;

    if (ctl.pkt_start) begin
      stuffing_nxt = 1'b0;
    end
    if (ctl.sec_reset) begin
      in_section_nxt = 1'b0;
      stuffing_nxt   = 1'b0;
    end
    if (ctl.payload && !stuffing_r && !in_section_r) begin
      if (byte_i == STUFF_BYTE) begin
        stuffing_nxt = 1'b1;
      end else begin
        open_sec = 1'b1;
      end
    end
    take = ctl.payload && !stuffing_r && (in_section_r || open_sec);

    count_b = open_sec ? 13'd0 : count_r;
    total_b = open_sec ? SEC_TOTAL_INIT : total_r;
    crc_b   = open_sec ? CRC_INIT : crc_r;

    if (take) begin
      in_section_nxt = 1'b1;
      if (open_sec) begin
        for (int i = 0; i < CAPTURE_BYTES; i++) begin
          cap_nxt[i] = '0;
        end
      end
      if (count_b < 13'(CAPTURE_BYTES)) begin
        cap_nxt[count_b[IDX_W-1:0]] = byte_i;
      end
      // section_length lives in the low nibble of byte 1 and byte 2
      if (count_b == 13'd2) begin
        total_nxt = 13'd3 + {5'd0, byte_i} + {1'b0, cap_nxt[1][3:0], 8'h00};
      end else begin
        total_nxt = total_b;
      end
      crc_nxt   = crc_byte(crc_b, byte_i);
      count_nxt = count_b + 13'd1;
      if (count_nxt == total_nxt) begin
        in_section_nxt = 1'b0;
        res_valid      = 1'b1;
      end
    end
  end

  always_comb begin
    res.crc_ok             = (crc_nxt == 32'h0);
    res.section_bytes      = total_nxt;
    res.table_id_extension = {cap_nxt[3], cap_nxt[4]};
    res.version            = cap_nxt[5][5:1];
    res.first_program      = {cap_nxt[8], cap_nxt[9]};
    res.map_pid            = {cap_nxt[10][4:0], cap_nxt[11]};
    res.stream_type        = cap_nxt[12];
    res.es_pid             = {cap_nxt[13][4:0], cap_nxt[14]};
    res.mac_address        = {cap_nxt[11], cap_nxt[10], cap_nxt[9], cap_nxt[8],
                              cap_nxt[4], cap_nxt[3]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_section_r <= 1'b0;
      stuffing_r   <= 1'b0;
      count_r      <= '0;
      total_r      <= SEC_TOTAL_INIT;
    end else begin
      in_section_r <= in_section_nxt;
      stuffing_r   <= stuffing_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
    end
  end

  // datapath, only read once a section has been opened
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    cap_r <= cap_nxt;
  end

  assign stat.in_section      = in_section_r;
  assign stat.stuffing        = stuffing_r;
  assign stat.cnt_below_total = (count_r < total_r);

endmodule

// ===== hw/rtl/ts_section_assembler_crc_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TS section assembler with CRC-32 check
// Frames a transport stream, assembles PSI/data sections of one PID and
// reports each completed section with its CRC verdict and header fields.
// ----------------------------------------------------------------------------
// Takes one transport-stream byte per cycle on in_* and keeps that rate
// while out_tready is high; a result waiting in the output register holds
// the input off until it is taken. Each byte is one item, registered on
// entry and then decoded by the framer and section unit. The result of
// the byte that closes a section enters the output register as that byte
// is decoded; a full output register holds that byte in the input register
// until freed. The path that sets the clock is the byte-wide CRC-32 update
// feeding the zero-residue compare. The framer hunts for 0x47, counts
// PACKET_BYTES per packet and re-hunts after each packet. Only packets whose
// PID equals pid_filter (APB register 0, byte address 0) feed the section
// unit; payload begins at byte 5 in a start packet (pointer field taken as
// zero) and at byte 4 otherwise, and adaptation fields are not parsed. A
// start packet drops any partial section. After a section ends, a 0xFF byte
// marks the rest of the packet as stuffing; anything else opens a new
// section. One item leaves per completed section. Header fields lying past
// the end of a short section read as zero. Write pid_filter only while the
// block is idle.
// ----------------------------------------------------------------------------
`include "ts_section_assembler_crc_unit_macros.svh"

module ts_section_assembler_crc_unit
  import ts_sa_pkg::*;
#(
  parameter int PACKET_BYTES  = 188,
  parameter int CAPTURE_BYTES = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,     // [7:0] stream_byte
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] crc_ok, [13:1] section_bytes, [29:14] table_id_extension,
  // [34:30] version, [50:35] first_program, [63:51] map_pid,
  // [71:64] stream_type, [84:72] es_pid, [132:85] mac_address, rest zero
  output logic [135:0] out_tdata,
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // --- configuration -------------------------------------------------------
  logic [12:0] pid_filter_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_filter_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_PID_FILTER) begin
      pid_filter_r <= cfg_pwdata[12:0];
    end
  end

  // only one register; any other address reads as zero
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_PID_FILTER && cfg_paddr[1:0] == 2'b00) begin
      cfg_prdata = {19'd0, pid_filter_r};
    end
  end

  // --- input register ------------------------------------------------------
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic       out_free;
  logic       step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // --- framing and section assembly ----------------------------------------
  ts_sa_ctl_t      ctl;
  ts_sa_frm_stat_t frm_stat;
  ts_sa_sec_stat_t sec_stat;
  logic            res_valid;
  ts_sa_result_t   res;

  ts_sa_framer #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .byte_i     (in_byte_r),
    .pid_filter (pid_filter_r),
    .ctl        (ctl),
    .stat       (frm_stat)
  );

  ts_sa_section #(
    .CAPTURE_BYTES (CAPTURE_BYTES)
  ) u_section (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .byte_i    (in_byte_r),
    .res_valid (res_valid),
    .res       (res),
    .stat      (sec_stat)
  );

  // --- result register -----------------------------------------------------
  ts_sa_result_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  // --- checks --------------------------------------------------------------
  `TSSA_ASSERT_NOW(a_hunt_pos, frm_stat.hunting, frm_stat.pos_zero, "hunting off position zero")
  `TSSA_ASSERT_NOW(a_sec_stuff, sec_stat.in_section, !sec_stat.stuffing, "stuffing in section")
  `TSSA_ASSERT_NOW(a_sec_count, sec_stat.in_section, sec_stat.cnt_below_total, "count past length")
  `TSSA_ASSERT_NEXT(a_res_close, res_valid, !sec_stat.in_section && out_valid_r, "no close")

endmodule
